FILE: rtl/btmx_pkg.sv
// Package for the binary trie maximum-XOR block.
// Holds sizes, request and status codes and the node entry type.
// Depends on nothing; used by the interfaces and by binary_trie_max_xor_top.
package btmx_pkg;

	// Key length in bits and size of the node pool
	localparam int KEY_BITS   = 26;
	localparam int NODE_COUNT = 65536;

	localparam int NODE_W  = $clog2(NODE_COUNT);
	localparam int LEVEL_W = (KEY_BITS > 1) ? $clog2(KEY_BITS) : 1;

	// Request codes
	localparam logic REQ_INSERT = 1'b0;
	localparam logic REQ_QUERY  = 1'b1;

	// Status codes
	typedef logic [1:0] status_t;
	localparam status_t ST_OK    = 2'd0;
	localparam status_t ST_EMPTY = 2'd1;
	localparam status_t ST_FULL  = 2'd2;

	typedef logic [KEY_BITS-1:0] key_t;
	typedef logic [NODE_W-1:0]   node_t;
	typedef logic [NODE_W:0]     count_t;

	// One trie node: index 0 is child for bit 0, index 1 for bit 1; zero means no child
	typedef logic [1:0][NODE_W-1:0] entry_t;

endpackage

FILE: rtl/btmx_req_if.sv
// Request channel of the binary trie maximum-XOR block.
// Carries valid, ready, request type and key. Depends on btmx_pkg.
interface btmx_req_if import btmx_pkg::*; ();
	logic valid;
	logic ready;
	logic req_type;
	key_t key_value;

	modport source (output valid, output req_type, output key_value, input ready);
	modport sink   (input valid, input req_type, input key_value, output ready);
endinterface

FILE: rtl/btmx_rsp_if.sv
// Response channel of the binary trie maximum-XOR block.
// Carries valid, ready, the XOR result and the status. Depends on btmx_pkg.
interface btmx_rsp_if import btmx_pkg::*; ();
	logic    valid;
	logic    ready;
	key_t    xor_max;
	status_t status;

	modport source (output valid, output xor_max, output status, input ready);
	modport sink   (input valid, input xor_max, input status, output ready);
endinterface

FILE: rtl/binary_trie_max_xor_top.sv
// Binary trie maximum-XOR block: node pool in one synchronous RAM, walk sequencer.
// Depends on btmx_pkg, btmx_req_if and btmx_rsp_if.
//
// Takes one request word at a time and returns one response word for each. The root
// read is issued at the accepting edge. An insert or a query on a non-empty trie then
// walks the key bits from the top down, one level at a time, since the node RAM has a
// single read port and each level's address comes from the previous level's read data,
// and then loads the response register; the next request can be taken once that
// register is loaded. A query that meets a node with no child ends its walk early.
// A query on an empty trie or a refused insert (fewer than KEY_BITS free nodes) skips
// the walk and goes straight to loading its response. The next request is taken
// while a finished response still waits; a response that cannot be loaded because the
// previous one is not yet taken holds the block, which stalls its input.
// No clearing pass runs after reset: nodes at or above the allocation count, and the
// root before the first insert, read as empty, and a fresh node's entry is written
// before it is ever read.
module binary_trie_max_xor_top import btmx_pkg::*; (
	input  logic           clk,
	input  logic           arst_n,
	btmx_req_if.sink       req,
	btmx_rsp_if.source     rsp
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_WALK,
		S_DONE
	} state_t;

	state_t               state_q;
	logic                 op_q;
	key_t                 key_q;
	logic [LEVEL_W-1:0]   level_q;
	node_t                node_q;
	logic                 fresh_q;
	count_t               next_free_q;
	logic                 has_keys_q;
	key_t                 acc_q;
	status_t              res_status_q;

	logic                 rsp_valid_q;
	key_t                 rsp_xor_q;
	status_t              rsp_status_q;

	// Node pool
	entry_t               node_mem [NODE_COUNT];
	entry_t               rd_data_s1;
	node_t                rd_addr;
	logic                 wr_en;
	entry_t               wr_data;

	logic                 accept;
	logic                 pool_full;
	logic                 key_bit;
	entry_t               ent;
	node_t                other;
	node_t                same;
	node_t                next_node;
	logic                 take_other;
	logic                 stop;
	logic                 alloc;
	logic                 rsp_free;

	assign accept   = req.valid && req.ready;
	assign rsp_free = !rsp_valid_q || rsp.ready;

	assign req.ready   = (state_q == S_IDLE);
	assign rsp.valid   = rsp_valid_q;
	assign rsp.xor_max = rsp_xor_q;
	assign rsp.status  = rsp_status_q;

	// Refuse an insert unless KEY_BITS nodes remain
	assign pool_full = (count_t'(next_free_q + count_t'(KEY_BITS)) > count_t'(NODE_COUNT));

	// Decode one level of the walk from the registered read data
	always_comb begin
		key_bit    = key_q[level_q];
		ent        = fresh_q ? entry_t'('0) : rd_data_s1;
		other      = ent[!key_bit];
		same       = ent[key_bit];
		take_other = 1'b0;
		stop       = 1'b0;
		alloc      = 1'b0;
		wr_data    = ent;
		next_node  = same;
		if (op_q == REQ_INSERT) begin
			if (same == '0) begin
				alloc     = 1'b1;
				next_node = next_free_q[NODE_W-1:0];
				wr_data[key_bit] = next_free_q[NODE_W-1:0];
			end
		end else begin
			if (other != '0) begin
				take_other = 1'b1;
				next_node  = other;
			end else if (same == '0) begin
				stop = 1'b1;
			end
		end
		wr_en   = (state_q == S_WALK) && alloc;
		rd_addr = (state_q == S_WALK) ? next_node : node_t'(0);
	end

	// Node RAM: one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (wr_en) begin
			node_mem[node_q] <= wr_data;
		end
		rd_data_s1 <= node_mem[rd_addr];
	end

	// Sequencer, allocation state and response register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			next_free_q  <= count_t'(1);
			has_keys_q   <= 1'b0;
			rsp_valid_q  <= 1'b0;
			op_q         <= REQ_INSERT;
			key_q        <= '0;
			level_q      <= '0;
			node_q       <= '0;
			fresh_q      <= 1'b0;
			acc_q        <= '0;
			res_status_q <= ST_OK;
			rsp_xor_q    <= '0;
			rsp_status_q <= ST_OK;
		end else begin
			// Load a finished result, drop the response once taken
			if (state_q == S_DONE && rsp_free) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_valid_q && rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						op_q    <= req.req_type;
						key_q   <= req.key_value;
						level_q <= LEVEL_W'(KEY_BITS - 1);
						node_q  <= '0;
						fresh_q <= !has_keys_q;
						acc_q   <= '0;
						if (req.req_type == REQ_INSERT && pool_full) begin
							res_status_q <= ST_FULL;
							state_q      <= S_DONE;
						end else if (req.req_type == REQ_QUERY && !has_keys_q) begin
							res_status_q <= ST_EMPTY;
							state_q      <= S_DONE;
						end else begin
							res_status_q <= ST_OK;
							state_q      <= S_WALK;
						end
					end
				end
				S_WALK: begin
					// Advance one level
					node_q  <= next_node;
					level_q <= level_q - LEVEL_W'(1);
					if (alloc) begin
						next_free_q <= next_free_q + count_t'(1);
						fresh_q     <= 1'b1;
					end
					if (take_other) begin
						acc_q[level_q] <= 1'b1;
					end
					if (stop || level_q == '0) begin
						if (op_q == REQ_INSERT) begin
							has_keys_q <= 1'b1;
						end
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					// Hold the result until the response register is free
					if (rsp_free) begin
						rsp_xor_q    <= (op_q == REQ_QUERY && res_status_q == ST_OK) ?
							acc_q : key_t'(0);
						rsp_status_q <= res_status_q;
						state_q      <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule
